// ----- rtl/json_tokenizer_macros.svh -----
`ifndef JSON_TOKENIZER_MACROS_SVH
`define JSON_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define JT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("json_tokenizer check failed");

// Next-cycle implication, disabled while reset is high.
`define JT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("json_tokenizer check failed");

`endif

// ----- rtl/jt_pkg.sv -----
`timescale 1ns / 1ps
package jt_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT   = 4;

   localparam logic [3:0] KIND_ERROR    = 4'd0;
   localparam logic [3:0] KIND_COLON    = 4'd1;
   localparam logic [3:0] KIND_COMMA    = 4'd2;
   localparam logic [3:0] KIND_LBRACE   = 4'd3;
   localparam logic [3:0] KIND_RBRACE   = 4'd4;
   localparam logic [3:0] KIND_LBRACKET = 4'd5;
   localparam logic [3:0] KIND_RBRACKET = 4'd6;
   localparam logic [3:0] KIND_TRUE     = 4'd7;
   localparam logic [3:0] KIND_FALSE    = 4'd8;
   localparam logic [3:0] KIND_NULL     = 4'd9;
   localparam logic [3:0] KIND_INT      = 4'd10;
   localparam logic [3:0] KIND_DECIMAL  = 4'd11;
   localparam logic [3:0] KIND_STRING   = 4'd12;
   localparam logic [3:0] KIND_EOF      = 4'd13;

   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_T        = 8'h74;
   localparam logic [7:0] CH_F        = 8'h66;
   localparam logic [7:0] CH_N        = 8'h6E;

   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
   } token_type;

   typedef struct packed {
      token_type first;
      token_type second;
      logic      two;
   } entry_type;

   function automatic logic [2:0] kw_len(input logic [1:0] k);
      return (k == KW_FALSE) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [3:0] kw_token(input logic [1:0] k);
      logic [3:0] t;
      unique case (k)
         KW_FALSE: t = KIND_FALSE;
         KW_NULL:  t = KIND_NULL;
         default:  t = KIND_TRUE;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
      logic [7:0] c;
      unique case ({k, idx})
         {KW_FALSE, 3'd0}: c = "f";
         {KW_FALSE, 3'd1}: c = "a";
         {KW_FALSE, 3'd2}: c = "l";
         {KW_FALSE, 3'd3}: c = "s";
         {KW_FALSE, 3'd4}: c = "e";
         {KW_NULL, 3'd0}:  c = "n";
         {KW_NULL, 3'd1}:  c = "u";
         {KW_NULL, 3'd2}:  c = "l";
         {KW_NULL, 3'd3}:  c = "l";
         {KW_TRUE, 3'd0}:  c = "t";
         {KW_TRUE, 3'd1}:  c = "r";
         {KW_TRUE, 3'd2}:  c = "u";
         {KW_TRUE, 3'd3}:  c = "e";
         default:          c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/jt_queue.sv -----
`timescale 1ns / 1ps
module jt_queue #(
   parameter int DEPTH = jt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jt_pkg::entry_type push_entry,
   output logic              full,
   output logic              head_valid,
   output jt_pkg::entry_type head_entry,
   input  logic              pop
);
   import jt_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/jt_front.sv -----
`timescale 1ns / 1ps
module jt_front #(
   parameter int POSITION_BITS = jt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        text_byte,
   input  logic              end_of_text,
   output logic              push,
   output jt_pkg::entry_type push_entry
);
   import jt_pkg::*;

   localparam int PB = POSITION_BITS;

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_WORD = 3'd1;
   localparam logic [2:0] MODE_INT  = 3'd2;
   localparam logic [2:0] MODE_FRAC = 3'd3;
   localparam logic [2:0] MODE_STR  = 3'd4;

   function automatic logic [15:0] sat16(input logic [PB-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   logic [2:0]    mode_ff, mode_in;
   logic [1:0]    kw_ff, kw_in;
   logic          match_ff, match_in;
   logic [2:0]    seen_ff, seen_in;
   logic [PB-1:0] start_ff, start_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic [PB-1:0] line_ff, line_in;
   logic [15:0]   run_ff, run_in;

   logic [1:0]    k;
   logic [15:0]   grown;
   logic [3:0]    flush_kind;
   logic [15:0]   flush_len;
   logic          fl_v, dv, dispatch;
   logic          is_letter, is_digit;
   token_type     fl_tok, d_tok;

   assign k         = (kw_ff == 2'd3) ? KW_TRUE : kw_ff;
   assign grown     = (run_ff == 16'hFFFF) ? run_ff : run_ff + 16'd1;
   assign is_letter = (text_byte >= "a" && text_byte <= "z") ||
                      (text_byte >= "A" && text_byte <= "Z");
   assign is_digit  = (text_byte >= "0" && text_byte <= "9");

   always_comb begin
      unique case (mode_ff)
         MODE_WORD: flush_kind = (match_ff && seen_ff >= kw_len(k)) ? kw_token(k) : KIND_ERROR;
         MODE_INT:  flush_kind = KIND_INT;
         MODE_FRAC: flush_kind = KIND_DECIMAL;
         MODE_STR:  flush_kind = KIND_STRING;
         default:   flush_kind = KIND_ERROR;
      endcase
      flush_len = (mode_ff == MODE_STR && !end_of_text) ? grown : run_ff;
   end

   always_comb begin
      mode_in  = mode_ff;
      kw_in    = kw_ff;
      match_in = match_ff;
      seen_in  = seen_ff;
      start_in = start_ff;
      pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + PB'(1);
      line_in  = line_ff;
      run_in   = run_ff;
      fl_v     = 1'b0;
      dv       = 1'b0;
      dispatch = 1'b0;
      fl_tok   = '{kind: flush_kind, offset: sat16(start_ff), length: flush_len,
                   line: sat16(line_ff)};
      d_tok    = '{kind: KIND_ERROR, offset: sat16(pos_ff), length: 16'd1,
                   line: sat16(line_ff)};

      if (end_of_text) begin
         fl_v         = (mode_ff == MODE_WORD) || (mode_ff == MODE_INT) ||
                        (mode_ff == MODE_FRAC) || (mode_ff == MODE_STR);
         dv           = 1'b1;
         d_tok.kind   = KIND_EOF;
         d_tok.length = 16'd0;
         mode_in      = MODE_IDLE;
         kw_in        = KW_TRUE;
         match_in     = 1'b1;
         seen_in      = 3'd0;
         start_in     = '0;
         pos_in       = '0;
         line_in      = PB'(1);
         run_in       = 16'd0;
      end else begin
         unique case (mode_ff)
            MODE_WORD: begin
               if (is_letter) begin
                  if (seen_ff < kw_len(k) && kw_char(k, seen_ff) != text_byte) begin
                     match_in = 1'b0;
                  end
                  if (seen_ff != 3'd7) begin
                     seen_in = seen_ff + 3'd1;
                  end
                  run_in = grown;
               end else begin
                  fl_v     = 1'b1;
                  dispatch = 1'b1;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_INT: begin
               if (is_digit) begin
                  run_in = grown;
               end else if (text_byte == CH_DOT) begin
                  mode_in = MODE_FRAC;
                  run_in  = grown;
               end else begin
                  fl_v     = 1'b1;
                  dispatch = 1'b1;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_FRAC: begin
               if (is_digit) begin
                  run_in = grown;
               end else begin
                  fl_v     = 1'b1;
                  dispatch = 1'b1;
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_STR: begin
               run_in = grown;
               if (text_byte == CH_QUOTE) begin
                  fl_v    = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in  = MODE_IDLE;
               dispatch = 1'b1;
            end
         endcase

         if (dispatch) begin
            unique case (text_byte)
               CH_SPACE, CH_TAB, CH_CR: begin
               end
               CH_NEWLINE: begin
                  if (line_ff != '1) begin
                     line_in = line_ff + PB'(1);
                  end
               end
               CH_COLON: begin
                  dv         = 1'b1;
                  d_tok.kind = KIND_COLON;
               end
               CH_COMMA: begin
                  dv         = 1'b1;
                  d_tok.kind = KIND_COMMA;
               end
               CH_LBRACE: begin
                  dv         = 1'b1;
                  d_tok.kind = KIND_LBRACE;
               end
               CH_RBRACE: begin
                  dv         = 1'b1;
                  d_tok.kind = KIND_RBRACE;
               end
               CH_LBRACKET: begin
                  dv         = 1'b1;
                  d_tok.kind = KIND_LBRACKET;
               end
               CH_RBRACKET: begin
                  dv         = 1'b1;
                  d_tok.kind = KIND_RBRACKET;
               end
               CH_T, CH_F, CH_N: begin
                  mode_in  = MODE_WORD;
                  kw_in    = (text_byte == CH_T) ? KW_TRUE :
                             ((text_byte == CH_F) ? KW_FALSE : KW_NULL);
                  match_in = 1'b1;
                  seen_in  = 3'd1;
                  start_in = pos_ff;
                  run_in   = 16'd1;
               end
               CH_QUOTE: begin
                  mode_in  = MODE_STR;
                  start_in = pos_ff;
                  run_in   = 16'd1;
               end
               default: begin
                  if (is_digit) begin
                     mode_in  = MODE_INT;
                     start_in = pos_ff;
                     run_in   = 16'd1;
                  end else begin
                     dv = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      push              = accept && (fl_v || dv);
      push_entry.first  = fl_v ? fl_tok : d_tok;
      push_entry.second = d_tok;
      push_entry.two    = fl_v && dv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         kw_ff    <= KW_TRUE;
         match_ff <= 1'b1;
         seen_ff  <= 3'd0;
         start_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= PB'(1);
         run_ff   <= 16'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         kw_ff    <= kw_in;
         match_ff <= match_in;
         seen_ff  <= seen_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         run_ff   <= run_in;
      end
   end

endmodule

// ----- rtl/jt_back.sv -----
`timescale 1ns / 1ps
module jt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  jt_pkg::entry_type head_entry,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_token_kind,
   output logic [15:0]       rsp_token_offset,
   output logic [15:0]       rsp_token_length,
   output logic [15:0]       rsp_line_number,
   output logic              rsp_last_of_run
);
   import jt_pkg::*;

   logic      phase_ff, phase_in;
   token_type cur;
   logic      fire;

   assign cur              = phase_ff ? head_entry.second : head_entry.first;
   assign rsp_valid        = head_valid;
   assign rsp_token_kind   = cur.kind;
   assign rsp_token_offset = cur.offset;
   assign rsp_token_length = cur.length;
   assign rsp_line_number  = cur.line;
   assign rsp_last_of_run  = phase_ff || !head_entry.two;
   assign fire             = rsp_valid && rsp_ready;
   assign pop              = fire && rsp_last_of_run;

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         phase_in = !rsp_last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- rtl/json_tokenizer.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Beat
// req      in   one text byte, or the end marker
// rsp      out  one token
//
// One byte is taken per cycle while the token queue has room.
// A byte yields up to two tokens; they share one queue entry and leave one per cycle
// while rsp_ready is high; the first reaches rsp when its entry is at the queue head.
// Reset is synchronous and clears the scanner state and the queue.
// A stalled rsp side fills the queue, and req_ready falls only when it is full.
module json_tokenizer #(
   parameter int POSITION_BITS = jt_pkg::POSITION_BITS_DEFAULT,
   parameter int QUEUE_DEPTH   = jt_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_token_offset,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last_of_run
);
   import jt_pkg::*;

   logic      accept, push, full, head_valid, pop;
   entry_type push_entry, head_entry;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   jt_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_text_byte),
      .end_of_text(req_end_of_text),
      .push       (push),
      .push_entry (push_entry)
   );

   jt_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (full),
      .head_valid(head_valid),
      .head_entry(head_entry),
      .pop       (pop)
   );

   jt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_offset(rsp_token_offset),
      .rsp_token_length(rsp_token_length),
      .rsp_line_number (rsp_line_number),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- rtl/jt_checker.sv -----
`timescale 1ns / 1ps
`include "json_tokenizer_macros.svh"
module jt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_token_kind,
   input logic [15:0] rsp_token_offset,
   input logic [15:0] rsp_token_length,
   input logic [15:0] rsp_line_number,
   input logic        rsp_last_of_run
);
   import jt_pkg::*;

   logic        eof_beat, punct_beat, rsp_wait, pair_open;
   logic [52:0] rsp_beat;

   assign eof_beat   = rsp_valid && (rsp_token_kind == KIND_EOF);
   assign punct_beat = rsp_valid && (rsp_token_kind >= KIND_COLON) &&
                       (rsp_token_kind <= KIND_RBRACKET);
   assign rsp_wait   = rsp_valid && !rsp_ready;
   assign pair_open  = rsp_valid && rsp_ready && !rsp_last_of_run;
   assign rsp_beat   = {rsp_token_kind, rsp_token_offset, rsp_token_length,
                        rsp_line_number, rsp_last_of_run};

   // The end-of-text token closes its run and carries no bytes.
   `JT_ASSERT_NOW(eof_is_last, clock, reset, eof_beat, rsp_last_of_run && rsp_token_length == 16'd0)
   // Punctuation tokens always span one byte.
   `JT_ASSERT_NOW(punct_one_byte, clock, reset, punct_beat, rsp_token_length == 16'd1)
   // Lines are counted from one.
   `JT_ASSERT_NOW(line_from_one, clock, reset, rsp_valid, rsp_line_number != 16'd0)
   // The second token of a byte follows its first without a gap.
   `JT_ASSERT_NEXT(pair_back_to_back, clock, reset, pair_open, rsp_valid)
   // A waiting result beat stays offered and unchanged.
   `JT_ASSERT_NEXT(rsp_held, clock, reset, rsp_wait, rsp_valid && $stable(rsp_beat))

endmodule

bind json_tokenizer jt_checker u_jt_checker (.*);

// ----- test/tb_json_tokenizer.sv -----
`timescale 1ns / 1ps
module tb_json_tokenizer;
   import jt_pkg::*;

   localparam int unsigned POSITION_MAX   = (1 << POSITION_BITS_DEFAULT) - 1;
   localparam int unsigned LENGTH_MAX     = 65535;
   localparam int          RANDOM_ITEMS   = 1950;
   localparam int          HOLD_OFF_BEATS = 80;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          DRAIN_CYCLES   = 16;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_WORD,
      SCAN_INT,
      SCAN_FRAC,
      SCAN_STRING
   } scan_mode_type;

   typedef struct {
      logic [3:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line_no;
      logic        last;
   } beat_type;

   class token_scoreboard;
      scan_mode_type mode;
      logic [1:0]    kw_index;
      bit            kw_match;
      int unsigned   letters;
      int unsigned   start_pos;
      int unsigned   position;
      int unsigned   line_count;
      int unsigned   run_length;
      string         keywords[3];
      beat_type      expected_tokens[$];
      beat_type      step_tokens[$];
      int            error_count;

      function new();
         keywords[KW_TRUE]  = "true";
         keywords[KW_FALSE] = "false";
         keywords[KW_NULL]  = "null";
         error_count = 0;
         clear();
      endfunction

      function void clear();
         mode = SCAN_IDLE;
         kw_index = KW_TRUE;
         kw_match = 1'b1;
         letters = 0;
         start_pos = 0;
         position = 0;
         line_count = 1;
         run_length = 0;
      endfunction

      function int outstanding();
         return expected_tokens.size();
      endfunction

      function logic [15:0] clip16(int unsigned v);
         return (v > LENGTH_MAX) ? 16'hFFFF : 16'(v);
      endfunction

      function bit is_letter(logic [7:0] b);
         return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function void add_token(logic [3:0] kind, int unsigned off, int unsigned len);
         beat_type t;
         t.kind = kind;
         t.offset = clip16(off);
         t.length = clip16(len);
         t.line_no = clip16(line_count);
         t.last = 1'b0;
         step_tokens.push_back(t);
      endfunction

      function void grow();
         if (run_length < LENGTH_MAX) run_length++;
      endfunction

      function void close_pending();
         logic [3:0] kind;
         case (mode)
            SCAN_WORD: begin
               if (kw_match && letters >= keywords[kw_index].len())
                  kind = (kw_index == KW_FALSE) ? KIND_FALSE :
                         (kw_index == KW_NULL) ? KIND_NULL : KIND_TRUE;
               else
                  kind = KIND_ERROR;
            end
            SCAN_INT:    kind = KIND_INT;
            SCAN_FRAC:   kind = KIND_DECIMAL;
            SCAN_STRING: kind = KIND_STRING;
            default:     return;
         endcase
         add_token(kind, start_pos, run_length);
         mode = SCAN_IDLE;
      endfunction

      function void begin_run(scan_mode_type m);
         mode = m;
         start_pos = position;
         run_length = 1;
      endfunction

      function void note_byte(logic [7:0] b, logic eot);
         bit consumed;
         consumed = 1'b0;
         step_tokens.delete();
         if (eot) begin
            close_pending();
            add_token(KIND_EOF, position, 0);
            clear();
         end else begin
            case (mode)
               SCAN_WORD: begin
                  if (is_letter(b)) begin
                     if (letters < keywords[kw_index].len() &&
                         keywords[kw_index][letters] != b)
                        kw_match = 1'b0;
                     if (letters < 7) letters++;
                     grow();
                     consumed = 1'b1;
                  end else begin
                     close_pending();
                  end
               end
               SCAN_INT: begin
                  if (is_digit(b)) begin
                     grow();
                     consumed = 1'b1;
                  end else if (b == CH_DOT) begin
                     mode = SCAN_FRAC;
                     grow();
                     consumed = 1'b1;
                  end else begin
                     close_pending();
                  end
               end
               SCAN_FRAC: begin
                  if (is_digit(b)) begin
                     grow();
                     consumed = 1'b1;
                  end else begin
                     close_pending();
                  end
               end
               SCAN_STRING: begin
                  grow();
                  if (b == CH_QUOTE) close_pending();
                  consumed = 1'b1;
               end
               default: ;
            endcase
            if (!consumed) begin
               case (b)
                  CH_SPACE, CH_TAB, CH_CR: ;
                  CH_NEWLINE:  if (line_count < POSITION_MAX) line_count++;
                  CH_COLON:    add_token(KIND_COLON, position, 1);
                  CH_COMMA:    add_token(KIND_COMMA, position, 1);
                  CH_LBRACE:   add_token(KIND_LBRACE, position, 1);
                  CH_RBRACE:   add_token(KIND_RBRACE, position, 1);
                  CH_LBRACKET: add_token(KIND_LBRACKET, position, 1);
                  CH_RBRACKET: add_token(KIND_RBRACKET, position, 1);
                  CH_T, CH_F, CH_N: begin
                     begin_run(SCAN_WORD);
                     kw_index = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
                     kw_match = 1'b1;
                     letters = 1;
                  end
                  CH_QUOTE: begin_run(SCAN_STRING);
                  default: begin
                     if (is_digit(b)) begin_run(SCAN_INT);
                     else add_token(KIND_ERROR, position, 1);
                  end
               endcase
            end
            if (position < POSITION_MAX) position++;
         end
         if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
         foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
      endfunction

      function void check_token(logic [3:0] kind, logic [15:0] offset, logic [15:0] length,
                                logic [15:0] line_no, logic last);
         beat_type want;
         if (expected_tokens.size() == 0) begin
            $error("unexpected token: kind %0d offset %0d length %0d", kind, offset, length);
            error_count++;
            return;
         end
         want = expected_tokens.pop_front();
         if (kind !== want.kind) begin
            $error("token_kind: expected %0d, actual %0d", want.kind, kind);
            error_count++;
         end
         if (offset !== want.offset) begin
            $error("token_offset: expected %0d, actual %0d", want.offset, offset);
            error_count++;
         end
         if (length !== want.length) begin
            $error("token_length: expected %0d, actual %0d", want.length, length);
            error_count++;
         end
         if (line_no !== want.line_no) begin
            $error("line_number: expected %0d, actual %0d", want.line_no, line_no);
            error_count++;
         end
         if (last !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, last);
            error_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_token_offset;
   logic [15:0] rsp_token_length;
   logic [15:0] rsp_line_number;
   logic        rsp_last_of_run;

   token_scoreboard sb = new();
   logic [7:0]      doc_bytes[$];
   bit              idle_on = 1'b1;
   bit              hold_off_request = 1'b0;
   int              items_sent = 0;
   int              idle_cycles = 0;

   json_tokenizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_byte(input logic [7:0] b, input logic eot, input int gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_text_byte = b;
      req_end_of_text = eot;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b, eot);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, pick_gap());
   endtask

   task automatic send_end();
      send_byte(8'($urandom_range(0, 255)), 1'b1, pick_gap());
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
   endfunction

   function automatic void add_space();
      logic [7:0] ws[4];
      ws = '{CH_SPACE, CH_TAB, CH_CR, CH_NEWLINE};
      if ($urandom_range(0, 9) < 3)
         repeat ($urandom_range(1, 2)) doc_bytes.push_back(ws[$urandom_range(0, 3)]);
   endfunction

   function automatic logic [7:0] random_letter();
      return ($urandom_range(0, 4) == 0) ? 8'("A" + $urandom_range(0, 25))
                                         : 8'("a" + $urandom_range(0, 25));
   endfunction

   function automatic void add_number();
      repeat ($urandom_range(1, 6)) doc_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) < 4) begin
         doc_bytes.push_back(CH_DOT);
         repeat ($urandom_range(0, 3)) doc_bytes.push_back(8'("0" + $urandom_range(0, 9)));
         if ($urandom_range(0, 19) == 0) doc_bytes.push_back(CH_DOT);
      end
   endfunction

   function automatic void add_string();
      int r;
      doc_bytes.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 8)) begin
         r = $urandom_range(0, 19);
         if (r == 0) doc_bytes.push_back(CH_NEWLINE);
         else if (r == 1) doc_bytes.push_back(8'($urandom_range(128, 255)));
         else if (r == 2) doc_bytes.push_back(8'($urandom_range(1, 31)));
         else doc_bytes.push_back(8'($urandom_range(35, 126)));
      end
      doc_bytes.push_back(CH_QUOTE);
   endfunction

   function automatic void add_keyword();
      string w;
      int    pick;
      pick = $urandom_range(0, 2);
      w = (pick == 0) ? "true" : (pick == 1) ? "false" : "null";
      case ($urandom_range(0, 9))
         0: w = w.substr(0, $urandom_range(0, w.len() - 2));
         1: repeat ($urandom_range(1, 6)) w = {w, string'(random_letter())};
         2: w[$urandom_range(1, w.len() - 1)] = random_letter();
         3: w[0] = random_letter();
         default: ;
      endcase
      push_text(w);
   endfunction

   function automatic void add_value(int depth);
      int r;
      int count;
      add_space();
      r = $urandom_range(0, 9);
      if (depth >= 3 && r >= 7) r = $urandom_range(0, 6);
      if (r < 2) begin
         add_number();
      end else if (r < 4) begin
         add_string();
      end else if (r < 7) begin
         add_keyword();
      end else if (r < 9) begin
         doc_bytes.push_back(CH_LBRACKET);
         count = $urandom_range(0, 3);
         for (int i = 0; i < count; i++) begin
            if (i > 0) doc_bytes.push_back(CH_COMMA);
            add_value(depth + 1);
         end
         add_space();
         doc_bytes.push_back(CH_RBRACKET);
      end else begin
         doc_bytes.push_back(CH_LBRACE);
         count = $urandom_range(0, 3);
         for (int i = 0; i < count; i++) begin
            if (i > 0) doc_bytes.push_back(CH_COMMA);
            add_space();
            add_string();
            add_space();
            doc_bytes.push_back(CH_COLON);
            add_value(depth + 1);
         end
         add_space();
         doc_bytes.push_back(CH_RBRACE);
      end
      add_space();
   endfunction

   // Each accepted result beat is checked against the oldest expected token.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_token(rsp_token_kind, rsp_token_offset, rsp_token_length,
                        rsp_line_number, rsp_last_of_run);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_BEATS) @(negedge clock);
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   initial begin
      int  r;
      bit  broken;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_text("{\"\n\":true,[1.5.]} ");
      send_byte(8'h00, 1'b0, pick_gap());
      send_end();
      send_text("nulls 9\"");
      send_end();

      idle_on = 1'b0;
      hold_off_request = 1'b1;
      repeat (2) send_text("[1,22,3.5,true,{},\"x\":7]");
      send_end();

      while (items_sent < RANDOM_ITEMS) begin
         doc_bytes.delete();
         idle_on = ($urandom_range(0, 3) != 0);
         broken = 1'b0;
         r = $urandom_range(0, 99);
         if (r < 70) begin
            add_value(0);
         end else if (r < 85) begin
            repeat ($urandom_range(1, 12)) doc_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            add_value(0);
            broken = 1'b1;
            doc_bytes = doc_bytes[0:$urandom_range(0, doc_bytes.size() - 1)];
         end
         foreach (doc_bytes[i]) send_byte(doc_bytes[i], 1'b0, pick_gap());
         if (broken || $urandom_range(0, 2) == 0) send_end();
      end
      send_end();
      req_valid = 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.outstanding() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
